FILE: sv/wsd_pkg.sv
package wsd_pkg;

  // Table size and derived widths
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int TAG_W      = 64;

  typedef enum logic [1:0] {
    ST_UNSTARTED = 2'd0,
    ST_FREE      = 2'd1,
    ST_BUSY      = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_RUN    = 2'd1,
    OP_FINISH = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_UNMANAGED   = 3'd1,
    STAT_STARTED     = 3'd2,
    STAT_RUNNING     = 3'd3,
    STAT_NO_FREE     = 3'd4,
    STAT_NOT_FOUND   = 3'd5
  } status_t;

  // Input item
  typedef struct packed {
    opcode_t          opcode;
    logic [3:0]       slot_index;
    logic [TAG_W-1:0] unit_id;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [2:0] status_code;
    logic [3:0] chosen_slot;
    logic       any_unstarted;
    logic       any_free;
    logic [4:0] free_count;
    logic       any_busy;
  } rsp_t;

  // Scan outcome over the managed slots
  typedef struct packed {
    logic              match_hit;
    logic [SLOT_W-1:0] match_slot;
    logic              free_hit;
    logic [SLOT_W-1:0] free_slot;
    logic [CNT_W-1:0]  unstarted_cnt;
    logic [CNT_W-1:0]  free_cnt;
    logic [CNT_W-1:0]  busy_cnt;
  } scan_t;

endpackage

FILE: sv/wsd_scan.sv
module wsd_scan
  import wsd_pkg::*;
(
  input  slot_state_t [SLOT_COUNT-1:0]            status,
  input  logic        [SLOT_COUNT-1:0][TAG_W-1:0] tags,
  input  logic        [SLOT_COUNT-1:0]            managed_mask,
  input  logic        [TAG_W-1:0]                 unit_id,
  output scan_t                                   scan
);

  logic [SLOT_COUNT-1:0] match_vec;
  logic [SLOT_COUNT-1:0] free_vec;
  logic [SLOT_COUNT-1:0] busy_vec;
  logic [SLOT_COUNT-1:0] unst_vec;

  // Per-slot classification, managed slots only
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      free_vec[i]  = managed_mask[i] && (status[i] == ST_FREE);
      busy_vec[i]  = managed_mask[i] && (status[i] == ST_BUSY);
      unst_vec[i]  = managed_mask[i] && !free_vec[i] && !busy_vec[i];
      match_vec[i] = busy_vec[i] && (tags[i] == unit_id);
    end
  end

  // Lowest-numbered match and free slot; counts
  always_comb begin
    scan = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        scan.match_hit  = 1'b1;
        scan.match_slot = SLOT_W'(i);
      end
      if (free_vec[i]) begin
        scan.free_hit  = 1'b1;
        scan.free_slot = SLOT_W'(i);
      end
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      scan.unstarted_cnt = scan.unstarted_cnt + CNT_W'(unst_vec[i]);
      scan.free_cnt      = scan.free_cnt + CNT_W'(free_vec[i]);
      scan.busy_cnt      = scan.busy_cnt + CNT_W'(busy_vec[i]);
    end
  end

endmodule

FILE: sv/wsd_slot_table.sv
module wsd_slot_table
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  input  logic [4:0] managed_slots,
  output logic       done,
  output rsp_t       result
);

  slot_state_t [SLOT_COUNT-1:0]            status;
  logic        [SLOT_COUNT-1:0][TAG_W-1:0] tags;
  logic        [SLOT_COUNT-1:0]            managed_mask;
  scan_t                                   scan;

  logic              start_in_range;
  logic [SLOT_W-1:0] start_slot;
  logic              do_start;
  logic              do_run;
  logic              do_finish;
  status_t           code;
  logic [SLOT_W-1:0] chosen;
  logic [CNT_W-1:0]  unst_after;
  logic [CNT_W-1:0]  free_after;
  logic [CNT_W-1:0]  busy_after;

  // Managed range as a mask
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      managed_mask[i] = (32'(i) < 32'(managed_slots));
    end
  end

  wsd_scan u_scan (
    .status       (status),
    .tags         (tags),
    .managed_mask (managed_mask),
    .unit_id      (cmd.unit_id),
    .scan         (scan)
  );

  // Decode the operation against the current table
  assign start_slot     = SLOT_W'(cmd.slot_index);
  assign start_in_range = (32'(cmd.slot_index) < 32'(SLOT_COUNT)) &&
                          ({1'b0, cmd.slot_index} < managed_slots);

  always_comb begin
    code      = STAT_OK;
    chosen    = '0;
    do_start  = 1'b0;
    do_run    = 1'b0;
    do_finish = 1'b0;
    unique case (cmd.opcode)
      OP_START: begin
        if (!start_in_range) begin
          code = STAT_UNMANAGED;
        end else if (status[start_slot] == ST_FREE || status[start_slot] == ST_BUSY) begin
          code = STAT_STARTED;
        end else begin
          do_start = 1'b1;
        end
      end
      OP_RUN: begin
        if (scan.match_hit) begin
          code = STAT_RUNNING;
        end else if (!scan.free_hit) begin
          code = STAT_NO_FREE;
        end else begin
          do_run = 1'b1;
          chosen = scan.free_slot;
        end
      end
      OP_FINISH: begin
        if (!scan.match_hit) begin
          code = STAT_NOT_FOUND;
        end else begin
          do_finish = 1'b1;
          chosen    = scan.match_slot;
        end
      end
      OP_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  // Counts after the step, from current counts plus the move made
  assign unst_after = scan.unstarted_cnt - CNT_W'(do_start);
  assign free_after = scan.free_cnt + CNT_W'(do_start) + CNT_W'(do_finish)
                      - CNT_W'(do_run);
  assign busy_after = scan.busy_cnt + CNT_W'(do_run) - CNT_W'(do_finish);

  // Slot status store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        status[i] <= ST_UNSTARTED;
      end
    end else if (cmd_valid) begin
      if (do_start) begin
        status[start_slot] <= ST_FREE;
      end
      if (do_run) begin
        status[scan.free_slot] <= ST_BUSY;
      end
      if (do_finish) begin
        status[scan.match_slot] <= ST_FREE;
      end
    end
  end

  // Tag store, written when a slot goes busy
  always_ff @(posedge clk) begin
    if (cmd_valid && do_run) begin
      tags[scan.free_slot] <= cmd.unit_id;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      result.status_code   <= code;
      result.chosen_slot   <= 4'(chosen);
      result.any_unstarted <= (unst_after != '0);
      result.any_free      <= (free_after != '0);
      result.free_count    <= 5'(free_after);
      result.any_busy      <= (busy_after != '0);
    end
  end

  // Every item gives exactly one result, in the following cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |=> done)
    else $error("item gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !cmd_valid |=> !done)
    else $error("result without item");

  // An error leaves the table unchanged
  a_error_stable: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (code != STAT_OK) |=> $stable(status))
    else $error("failed operation changed slot status");

  // A successful run marks the chosen slot busy with the new tag
  a_run_writes: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && do_run |=>
      (status[$past(scan.free_slot)] == ST_BUSY) &&
      (tags[$past(scan.free_slot)] == $past(cmd.unit_id)))
    else $error("run did not claim its slot");

endmodule

FILE: sv/work_slot_dispatch_table.sv
// Channel   Direction  Handshake                 Payload
// cmd       in         start & !busy             cmd_t: opcode, slot_index, unit_id
// result    out        done (one-cycle strobe)   rsp_t: status, slot, flags, count
// cfg       in         cfg_valid & cfg_ready     cfg_data: managed_slots
//
// An item is registered at acceptance into cmd_q and cmd_valid; its result is then
// registered into result together with done, so done is high while that result is valid.
// One item can be accepted every cycle while busy is low, each seeing the table left by the one before.
// The combinational path from cmd_q to result is tag compare, priority encode and counts.
// busy is high during reset and in the first cycle after it; there is no clearing pass.
// The receiver cannot stall: done marks each result for exactly one cycle.
module work_slot_dispatch_table
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd,
  output logic       done,
  output rsp_t       result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  logic       cmd_valid;
  cmd_t       cmd_q;
  logic [4:0] managed_slots;

  assign cfg_ready = 1'b1;

  // Busy during reset and right after it
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      managed_slots <= '0;
    end else if (cfg_valid && cfg_ready) begin
      managed_slots <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
    end
  end

  wsd_slot_table u_table (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd_q),
    .managed_slots (managed_slots),
    .done          (done),
    .result        (result)
  );

endmodule

FILE: sim/work_slot_dispatch_table_tb.sv
`timescale 1ns / 1ps

module work_slot_dispatch_table_tb;
  import wsd_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  // Slot table tracker: mirrors the table and holds the results still owed
  class dispatch_checker;
    slot_state_t      slot_st[SLOT_COUNT];
    logic [TAG_W-1:0] slot_tag[SLOT_COUNT];
    int unsigned      managed;
    rsp_t             owed_rsp[$];
    int               errors;

    function new();
      foreach (slot_st[i]) begin
        slot_st[i]  = ST_UNSTARTED;
        slot_tag[i] = '0;
      end
      managed = 0;
      errors  = 0;
    endfunction

    function void set_managed(logic [4:0] v);
      managed = v;
    endfunction

    function int pending();
      return owed_rsp.size();
    endfunction

    // Apply one item to the mirrored table and build its result
    function rsp_t predict_dispatch(cmd_t c);
      rsp_t r;
      int   n;
      int   hit;
      int   pick;
      int   nfree;
      r     = '0;
      n     = (managed > SLOT_COUNT) ? SLOT_COUNT : managed;
      hit   = -1;
      pick  = -1;
      nfree = 0;
      // lowest matching busy slot and lowest free slot
      for (int i = 0; i < n; i++) begin
        if (hit < 0 && slot_st[i] == ST_BUSY && slot_tag[i] == c.unit_id) hit = i;
        if (pick < 0 && slot_st[i] == ST_FREE) pick = i;
      end
      case (c.opcode)
        OP_START: begin
          if (c.slot_index >= n) r.status_code = STAT_UNMANAGED;
          else if (slot_st[c.slot_index] != ST_UNSTARTED) r.status_code = STAT_STARTED;
          else slot_st[c.slot_index] = ST_FREE;
        end
        OP_RUN: begin
          if (hit >= 0) r.status_code = STAT_RUNNING;
          else if (pick < 0) r.status_code = STAT_NO_FREE;
          else begin
            slot_st[pick]  = ST_BUSY;
            slot_tag[pick] = c.unit_id;
            r.chosen_slot  = 4'(pick);
          end
        end
        OP_FINISH: begin
          if (hit < 0) r.status_code = STAT_NOT_FOUND;
          else begin
            slot_st[hit]  = ST_FREE;
            r.chosen_slot = 4'(hit);
          end
        end
        default: ;
      endcase
      // summary flags over the managed range, after the update
      for (int i = 0; i < n; i++) begin
        if (slot_st[i] == ST_FREE) nfree++;
        else if (slot_st[i] == ST_BUSY) r.any_busy = 1'b1;
        else r.any_unstarted = 1'b1;
      end
      r.any_free   = (nfree != 0);
      r.free_count = 5'(nfree);
      return r;
    endfunction

    function void note_cmd(cmd_t c);
      owed_rsp = {owed_rsp, predict_dispatch(c)};
    endfunction

    function void cmp_field(string name, int e, int a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t e;
      if (owed_rsp.size() == 0) begin
        $display("%0t: result with nothing owed, expected none, got %p", $time, got);
        errors++;
        return;
      end
      e = owed_rsp.pop_front();
      cmp_field("status_code", e.status_code, got.status_code);
      cmp_field("chosen_slot", e.chosen_slot, got.chosen_slot);
      cmp_field("any_unstarted", e.any_unstarted, got.any_unstarted);
      cmp_field("any_free", e.any_free, got.any_free);
      cmp_field("free_count", e.free_count, got.free_count);
      cmp_field("any_busy", e.any_busy, got.any_busy);
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  cmd_t       cmd;
  logic       done;
  rsp_t       result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [4:0] cfg_data;

  dispatch_checker  sb = new();
  logic [TAG_W-1:0] id_pool[$];
  int               quiet_cycles;

  work_slot_dispatch_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Monitor: check results, track accepted items and writes, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_rsp(result);
      if (start && !busy) sb.note_cmd(cmd);
      if (cfg_valid && cfg_ready) sb.set_managed(cfg_data);
      if (done || (start && !busy) || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic cmd_t mk(opcode_t op, logic [3:0] idx, logic [TAG_W-1:0] id);
    cmd_t c;
    c.opcode     = op;
    c.slot_index = idx;
    c.unit_id    = id;
    return c;
  endfunction

  // Mostly run (mostly new ids) and finish (mostly live ids) traffic, with starts, queries and stray ids
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   r;
    int   j;
    c.opcode     = OP_QUERY;
    c.slot_index = 4'($urandom_range(15));
    c.unit_id    = {$urandom, $urandom};
    r            = $urandom_range(99);
    if (r < 12) begin
      c.opcode = OP_START;
    end else if (r < 52) begin
      c.opcode = OP_RUN;
      if (id_pool.size() > 0 && $urandom_range(9) < 2) begin
        c.unit_id = id_pool[$urandom_range(id_pool.size() - 1)];
      end else begin
        if ($urandom_range(9) < 2) c.unit_id = 64'($urandom_range(7));
        id_pool = {id_pool, c.unit_id};
        if (id_pool.size() > 24) void'(id_pool.pop_front());
      end
    end else if (r < 92) begin
      c.opcode = OP_FINISH;
      if (id_pool.size() > 0 && $urandom_range(9) < 8) begin
        j         = $urandom_range(id_pool.size() - 1);
        c.unit_id = id_pool[j];
        if ($urandom_range(3) != 0) id_pool.delete(j);
      end
    end
    return c;
  endfunction

  // Hold the item until it is taken; start stays up for back-to-back items
  task automatic send_cmd(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_managed(input logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [4:0] m;
    bit         idle_on;
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing managed: every operation but the query fails
    send_cmd(mk(OP_QUERY, 4'd0, '0));
    send_cmd(mk(OP_START, 4'd0, '0));
    send_cmd(mk(OP_RUN, 4'd0, 64'd5));
    send_cmd(mk(OP_FINISH, 4'd0, 64'd5));
    wait_drained();

    // full table: start, double start, run, duplicate, no free, finish
    write_managed(5'd16);
    send_cmd(mk(OP_START, 4'd15, '0));
    send_cmd(mk(OP_START, 4'd0, '1));
    send_cmd(mk(OP_START, 4'd15, '0));
    send_cmd(mk(OP_RUN, 4'd15, '1));
    send_cmd(mk(OP_RUN, 4'd0, '1));
    send_cmd(mk(OP_RUN, 4'd0, '0));
    send_cmd(mk(OP_RUN, 4'd0, 64'd123));
    send_cmd(mk(OP_FINISH, 4'd0, '1));
    send_cmd(mk(OP_FINISH, 4'd0, '1));
    send_cmd(mk(OP_QUERY, 4'd15, '1));
    wait_drained();

    // shrink: busy slot 15 drops out of view
    write_managed(5'd1);
    send_cmd(mk(OP_QUERY, 4'd0, '0));
    send_cmd(mk(OP_FINISH, 4'd0, '0));
    send_cmd(mk(OP_START, 4'd15, '0));
    send_cmd(mk(OP_RUN, 4'd0, '0));
    wait_drained();

    // regrow: two slots hold the same tag, lowest one wins
    write_managed(5'd31);
    send_cmd(mk(OP_FINISH, 4'd0, '0));
    send_cmd(mk(OP_FINISH, 4'd0, '0));
    send_cmd(mk(OP_QUERY, 4'd0, '0));

    // random phases, each under its own table size
    for (int ph = 0; ph < 16; ph++) begin
      wait_drained();
      if (ph == 0) m = 5'd16;
      else if (ph == 1) m = 5'd0;
      else if ($urandom_range(9) < 7) m = 5'($urandom_range(1, 16));
      else m = 5'($urandom_range(31));
      write_managed(m);
      idle_on = !(ph >= 4 && ph <= 6);
      for (int k = 0; k < 102; k++) begin
        send_cmd(random_cmd());
        if (idle_on && $urandom_range(99) < 13) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else if (idle_on && $urandom_range(199) == 0) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
